@@ hdl/sdcd_pkg.sv @@
// ----------------------------------------------------------------------------
// sdcd_pkg
// Shared constants and types for the single/double click detector.
// ----------------------------------------------------------------------------
package sdcd_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int WINDOW_WIDTH        = 8;
   localparam int CODE_WIDTH          = 2;
   localparam int PRESS_WIDTH         = 2;

   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 8'd50;

   typedef logic [CODE_WIDTH-1:0]  click_code_type;
   typedef logic [PRESS_WIDTH-1:0] press_count_type;

   localparam click_code_type CLICK_NONE   = 2'd0;
   localparam click_code_type CLICK_SINGLE = 2'd1;
   localparam click_code_type CLICK_DOUBLE = 2'd2;

   localparam press_count_type PRESS_NONE   = 2'd0;
   localparam press_count_type PRESS_ONE    = 2'd1;
   localparam press_count_type PRESS_TWO    = 2'd2;

endpackage

@@ hdl/single_double_click_detector_unit.sv @@
// ----------------------------------------------------------------------------
// single_double_click_detector_unit
// Classifies sampled ticks of an active-low button into single and double
// clicks, with a configurable wait window that is also the long-hold limit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  req_      in         req_valid / req_stall     req_key_level
//  rsp_      out        rsp_valid / rsp_stall     rsp_click_code
//  csr_      in         csr_write_enable          csr_write_data
//
//  One word per cycle while req_stall is low: the state update is one pass of
//  compare and increment logic from the state registers into the result register.
//  Each accepted word yields one result word in the result or skid register.
//  A two-entry output (result register plus skid register) lets a word be
//  taken while the result waits; req_stall rises only when both are full.
//  Synchronous active-high reset clears state and sets the window to 50.
// ----------------------------------------------------------------------------
module single_double_click_detector_unit #(
   parameter int COUNT_WIDTH = sdcd_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_key_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sdcd_pkg::CODE_WIDTH-1:0]     rsp_click_code,
   input  logic                                csr_write_enable,
   input  logic [sdcd_pkg::WINDOW_WIDTH-1:0]   csr_write_data
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [sdcd_pkg::WINDOW_WIDTH-1:0] window_ff;
   logic                              latch_ff, latch_in;
   logic                              edge_taken_ff, edge_taken_in;
   sdcd_pkg::press_count_type         press_count_ff, press_count_in;
   logic [COUNT_WIDTH-1:0]            wait_count_ff, wait_count_in;
   logic [COUNT_WIDTH-1:0]            held_count_ff, held_count_in;

   logic                              rsp_valid_ff;
   sdcd_pkg::click_code_type          rsp_code_ff;
   logic                              skid_valid_ff;
   sdcd_pkg::click_code_type          skid_code_ff;

   sdcd_pkg::click_code_type          code_in;
   logic                              accept;
   logic                              rsp_take;
   logic [COUNT_WIDTH-1:0]            window_ext;
   sdcd_pkg::press_count_type         press_step;
   logic                              edge_step;
   logic [COUNT_WIDTH-1:0]            wait_step;

   assign accept     = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_click_code = rsp_code_ff;
   assign window_ext = {{(COUNT_WIDTH-sdcd_pkg::WINDOW_WIDTH){1'b0}}, window_ff};

   always_comb begin
      held_count_in  = req_key_level ? '0 :
                       ((held_count_ff != CNT_MAX) ? held_count_ff + 1'b1 : CNT_MAX);
      latch_in       = latch_ff || !req_key_level;
      edge_taken_in  = edge_taken_ff;
      press_count_in = press_count_ff;
      wait_count_in  = wait_count_ff;
      code_in        = sdcd_pkg::CLICK_NONE;
      press_step     = press_count_ff;
      edge_step      = edge_taken_ff;
      wait_step      = (wait_count_ff != CNT_MAX) ? wait_count_ff + 1'b1 : CNT_MAX;

      if (!edge_taken_ff && latch_in) begin
         press_step = press_count_ff + 1'b1;
         edge_step  = 1'b1;
      end

      if (!edge_taken_ff && press_step == sdcd_pkg::PRESS_TWO) begin
         // second press: report at once, skip release and wait handling
         press_count_in = sdcd_pkg::PRESS_NONE;
         wait_count_in  = '0;
         edge_taken_in  = edge_step;
         code_in        = sdcd_pkg::CLICK_DOUBLE;
      end else begin
         press_count_in = press_step;
         edge_taken_in  = edge_step;
         if (req_key_level) begin
            latch_in      = 1'b0;
            edge_taken_in = 1'b0;
         end
         if (press_step == sdcd_pkg::PRESS_ONE) begin
            wait_count_in = wait_step;
            if (wait_step > window_ext && held_count_in < window_ext) begin
               press_count_in = sdcd_pkg::PRESS_NONE;
               wait_count_in  = '0;
               code_in        = sdcd_pkg::CLICK_SINGLE;
            end else if (held_count_in > window_ext) begin
               // long hold: drop the pending press
               press_count_in = sdcd_pkg::PRESS_NONE;
               wait_count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= sdcd_pkg::WINDOW_RESET;
         latch_ff       <= 1'b0;
         edge_taken_ff  <= 1'b0;
         press_count_ff <= sdcd_pkg::PRESS_NONE;
         wait_count_ff  <= '0;
         held_count_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            window_ff <= csr_write_data;
         end
         if (accept) begin
            latch_ff       <= latch_in;
            edge_taken_ff  <= edge_taken_in;
            press_count_ff <= press_count_in;
            wait_count_ff  <= wait_count_in;
            held_count_ff  <= held_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || rsp_take) begin
            // output free: load from skid first, else the new word
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         rsp_code_ff <= skid_valid_ff ? skid_code_ff : code_in;
      end
      if (rsp_valid_ff && !rsp_take && accept) begin
         skid_code_ff <= code_in;
      end
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while the output register is empty");

   a_press_pending: assert property (@(posedge clock) disable iff (reset)
      press_count_ff == sdcd_pkg::PRESS_NONE || press_count_ff == sdcd_pkg::PRESS_ONE)
      else $error("press count left above one");

   a_wait_idle: assert property (@(posedge clock) disable iff (reset)
      (wait_count_ff != '0) |-> (press_count_ff == sdcd_pkg::PRESS_ONE))
      else $error("wait counter running with no pending press");

   a_edge_latch: assert property (@(posedge clock) disable iff (reset)
      edge_taken_ff |-> latch_ff)
      else $error("press counted without a latched press");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid_ff && !skid_valid_ff))
      else $error("output not empty after reset");

endmodule
